@@ rtl/core/lucas_sequence_factor_coefficients_defines.svh @@
// assertion macros shared by the checker
`ifndef LUCAS_SEQUENCE_FACTOR_COEFFICIENTS_DEFINES_SVH
`define LUCAS_SEQUENCE_FACTOR_COEFFICIENTS_DEFINES_SVH

`define LSFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LSFC_ASSERT_NEXT(label, pre, post, msg) \
  `LSFC_ASSERT(label, (pre) |=> (post), msg)

`endif

@@ rtl/core/lsfc_pkg.sv @@
package lsfc_pkg;

  localparam int WORD_W        = 62;
  localparam int IDX_W         = 6;
  localparam int PAIR_CFG_W    = 5;
  localparam int DEF_MAX_PAIRS = 30;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 64;

  localparam logic [WORD_W-1:0]     MOD_RESET   = WORD_W'(7);
  localparam logic [PAIR_CFG_W-1:0] PAIRS_RESET = PAIR_CFG_W'(1);

  typedef enum logic [1:0] {
    FORM_MINUS = 2'd0,
    FORM_PLUS  = 2'd1,
    FORM_QUAD  = 2'd2
  } form_t;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_PAIRS   = 2'd1,
    REG_EXTRA   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic reduce;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

@@ rtl/core/lsfc_serial_mul.sv @@
module lsfc_serial_mul import lsfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mul_req_t          req,
  input  logic [WORD_W-1:0] modulus,
  input  logic [WORD_W-1:0] word,
  input  logic [WORD_W-1:0] addend,
  output mul_sts_t          sts,
  output logic [WORD_W-1:0] result
);

  localparam int CNT_W = $clog2(WORD_W);
  localparam int T_W   = WORD_W + 2;

  logic              busy_r;
  logic              done_r;
  logic              red_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] sh_r;
  logic [WORD_W-1:0] add_r;

  logic              msb;
  logic [WORD_W-1:0] add_val;
  logic [T_W-1:0]    t;
  logic [T_W-1:0]    m1;
  logic [T_W-1:0]    m2;
  logic [T_W-1:0]    step;
  logic [WORD_W-1:0] acc_nxt;

  // one bit per cycle: acc = (2*acc + digit term) mod m, msb first
  always_comb begin
    msb     = sh_r[WORD_W-1];
    add_val = red_r ? {{(WORD_W-1){1'b0}}, msb} : (msb ? add_r : '0);
    t       = {1'b0, acc_r, 1'b0} + {2'b00, add_val};
    m1      = {2'b00, modulus};
    m2      = {1'b0, modulus, 1'b0};
    if (t >= m2) begin
      step = t - m2;
    end else if (t >= m1) begin
      step = t - m1;
    end else begin
      step = t;
    end
    acc_nxt = step[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      sh_r  <= word;
      add_r <= addend;
      red_r <= req.reduce;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      sh_r  <= {sh_r[WORD_W-2:0], 1'b0};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = acc_r;

endmodule

@@ rtl/core/lucas_sequence_factor_coefficients.sv @@
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------------
// input     | in        | in_valid / in_ready    | in_generator
// result    | out       | out_valid / out_ready  | out_factor_index, out_form, out_coeff,
//           |           |                        | out_last
// config    | in        | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// the generator is reduced bit-serially in S_RED, then S_HEAD loads the head results (x-1, x+1
// and x^2+1 when enabled) and S_NEG/S_POS load the first pair; each later pair waits in S_MUL
// for a serial multiply and in S_SUB for a subtract, then S_NEG/S_POS load it; the S_POS result
// of the last pair (or the last head result when no pair is set) is the last result
// rst_n is synchronous; registers return to modulus 7, one pair, no x^2+1
// a stalled output holds the sequencer; a new item is taken once the last result is loaded
module lucas_sequence_factor_coefficients import lsfc_pkg::*; #(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WORD_W-1:0]     in_generator,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      out_factor_index,
  output logic [1:0]            out_form,
  output logic [WORD_W-1:0]     out_coeff,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_HEAD,
    S_NEG,
    S_POS,
    S_MUL,
    S_SUB
  } state_t;

  // configuration registers
  logic [WORD_W-1:0]     mod_cfg_r;
  logic [PAIR_CFG_W-1:0] pairs_cfg_r;
  logic                  extra_cfg_r;
  reg_idx_t              reg_idx;
  logic                  cfg_wr;

  // sequencer
  state_t                state_r;
  logic [WORD_W-1:0]     m_r;
  logic [WORD_W-1:0]     a_r;
  logic [WORD_W-1:0]     prev_r;
  logic [WORD_W-1:0]     curr_r;
  logic [WORD_W-1:0]     tmp_r;
  logic [PAIR_W-1:0]     npairs_r;
  logic [PAIR_W-1:0]     pi_r;
  logic                  extra_r;
  logic [1:0]            hd_r;
  logic [IDX_W-1:0]      idx_r;

  // output register
  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_idx_r;
  form_t                 out_form_r;
  logic [WORD_W-1:0]     out_coeff_r;
  logic                  out_last_r;

  logic                  in_acc;
  logic                  can_load;
  logic                  out_load;
  logic                  head_last;
  logic                  pos_last;
  form_t                 head_form;
  logic [WORD_W-1:0]     eff_mod;
  logic [PAIR_W-1:0]     sat_pairs;
  logic [WORD_W-1:0]     neg_coeff;
  logic [WORD_W-1:0]     sub_val;
  mul_req_t              mreq;
  mul_sts_t              msts;
  logic [WORD_W-1:0]     mres;
  logic [WORD_W-1:0]     mword;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cfg_r   <= MOD_RESET;
      pairs_cfg_r <= PAIRS_RESET;
      extra_cfg_r <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODULUS: mod_cfg_r   <= pwdata[WORD_W-1:0];
        REG_PAIRS:   pairs_cfg_r <= pwdata[PAIR_CFG_W-1:0];
        REG_EXTRA:   extra_cfg_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODULUS: prdata = {{(DATA_W-WORD_W){1'b0}}, mod_cfg_r};
      REG_PAIRS:   prdata = {{(DATA_W-PAIR_CFG_W){1'b0}}, pairs_cfg_r};
      REG_EXTRA:   prdata = {{(DATA_W-1){1'b0}}, extra_cfg_r};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    in_acc    = in_valid && in_ready;
    can_load  = !out_valid_r || out_ready;
    out_load  = can_load && (state_r inside {S_HEAD, S_NEG, S_POS});
    eff_mod   = (mod_cfg_r == '0) ? WORD_W'(1) : mod_cfg_r;
    sat_pairs = (int'(pairs_cfg_r) > MAX_PAIRS) ? PAIR_W'(MAX_PAIRS)
                                                : PAIR_W'(pairs_cfg_r);
    head_last = (npairs_r == '0) && (((hd_r == 2'd1) && !extra_r) || (hd_r == 2'd2));
    pos_last  = (pi_r == npairs_r);
    neg_coeff = (curr_r == '0) ? '0 : m_r - curr_r;
    sub_val   = tmp_r - prev_r + ((tmp_r < prev_r) ? m_r : '0);
    case (hd_r)
      2'd0:    head_form = FORM_MINUS;
      2'd1:    head_form = FORM_PLUS;
      default: head_form = FORM_QUAD;
    endcase
    mreq.reduce = in_acc;
    mreq.start  = in_acc || ((state_r == S_POS) && can_load && !pos_last);
    mword       = in_acc ? in_generator : curr_r;
  end

  lsfc_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .modulus (m_r),
    .word    (mword),
    .addend  (a_r),
    .sts     (msts),
    .result  (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            m_r      <= eff_mod;
            npairs_r <= sat_pairs;
            extra_r  <= extra_cfg_r;
            idx_r    <= IDX_W'(1);
            state_r  <= S_RED;
          end
        end
        S_RED: begin
          if (msts.done) begin
            a_r     <= mres;
            curr_r  <= mres;
            prev_r  <= (m_r <= WORD_W'(2)) ? '0 : WORD_W'(2);
            hd_r    <= 2'd0;
            pi_r    <= PAIR_W'(1);
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (can_load) begin
            out_idx_r   <= idx_r;
            out_form_r  <= head_form;
            out_coeff_r <= '0;
            out_last_r  <= head_last;
            idx_r       <= idx_r + 1'b1;
            if (head_last) begin
              state_r <= S_IDLE;
            end else if (((hd_r == 2'd1) && !extra_r) || (hd_r == 2'd2)) begin
              state_r <= S_NEG;
            end else begin
              hd_r <= hd_r + 1'b1;
            end
          end
        end
        S_NEG: begin
          if (can_load) begin
            out_idx_r   <= idx_r;
            out_form_r  <= FORM_QUAD;
            out_coeff_r <= neg_coeff;
            out_last_r  <= 1'b0;
            idx_r       <= idx_r + 1'b1;
            state_r     <= S_POS;
          end
        end
        S_POS: begin
          if (can_load) begin
            out_idx_r   <= idx_r;
            out_form_r  <= FORM_QUAD;
            out_coeff_r <= curr_r;
            out_last_r  <= pos_last;
            idx_r       <= idx_r + 1'b1;
            if (pos_last) begin
              state_r <= S_IDLE;
            end else begin
              pi_r    <= pi_r + 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (msts.done) begin
            tmp_r   <= mres;
            state_r <= S_SUB;
          end
        end
        S_SUB: begin
          curr_r  <= sub_val;
          prev_r  <= curr_r;
          state_r <= S_NEG;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_factor_index = out_idx_r;
  assign out_form         = out_form_r;
  assign out_coeff        = out_coeff_r;
  assign out_last         = out_last_r;

endmodule

@@ rtl/core/lsfc_checker.sv @@
`include "lucas_sequence_factor_coefficients_defines.svh"

module lsfc_checker import lsfc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  out_factor_index,
  input logic [1:0]        out_form,
  input logic [WORD_W-1:0] out_coeff,
  input logic              out_last
);

  `LSFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_coeff) && $stable(out_factor_index) && $stable(out_last), "stalled result changed")
  `LSFC_ASSERT(a_first_form, out_valid |-> ((out_factor_index == IDX_W'(1)) == (out_form == FORM_MINUS)), "x-1 not at first place")
  `LSFC_ASSERT(a_second_form, out_valid && (out_factor_index == IDX_W'(2)) |-> (out_form == FORM_PLUS), "x+1 not at second place")
  `LSFC_ASSERT(a_linear_coeff, out_valid && (out_form != FORM_QUAD) |-> (out_coeff == '0), "linear factor with coefficient")
  `LSFC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind lucas_sequence_factor_coefficients lsfc_checker u_lsfc_checker (.*);
